/* design/pte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pte_pkg;

  // code modes
  typedef enum logic [1:0] {
    MODE_NUMERIC = 2'd0,
    MODE_ALNUM   = 2'd1,
    MODE_ASCII   = 2'd2,
    MODE_SPARE   = 2'd3
  } code_mode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CODE_MODE  = 2'd0,
    REG_DIGIT_STOP = 2'd1,
    REG_ALNUM_STOP = 2'd2,
    REG_ASCII_STOP = 2'd3
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;

  // code widths
  localparam logic [2:0] WidthNumeric = 3'd4;
  localparam logic [2:0] WidthAlnum   = 3'd6;
  localparam logic [2:0] WidthAscii   = 3'd7;

  // character constants
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] AlphaBias  = 8'h37;
  localparam logic [7:0] OtherBias  = 8'h3D;

  // reset values of the registers
  localparam logic [3:0] DigitStopRst = 4'hF;
  localparam logic [5:0] AlnumStopRst = 6'h3F;
  localparam logic [6:0] AsciiStopRst = 7'h7F;

  typedef struct packed {
    code_mode_e mode;
    logic [3:0] digit_stop;
    logic [5:0] alnum_stop;
    logic [6:0] ascii_stop;
  } cfg_t;

  // one code, right-aligned, with its width
  typedef struct packed {
    logic [6:0] code;
    logic [2:0] width;
  } code_t;

  // one result byte
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } res_item_t;

  // all results of one item
  typedef struct packed {
    logic [1:0] count;
    res_item_t  first;
    res_item_t  second;
  } pack_res_t;

endpackage

`default_nettype wire

/* design/pte_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_marker;

  modport source (output valid, output text_char, output end_marker, input ready);
  modport sink (input valid, input text_char, input end_marker, output ready);
endinterface

`default_nettype wire

/* design/pte_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       final_byte;

  modport source (output valid, output packed_byte, output final_byte, input ready);
  modport sink (input valid, input packed_byte, input final_byte, output ready);
endinterface

`default_nettype wire

/* design/packed_text_encoder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake     payload
// in_ch     in   valid/ready   text_char[7:0], end_marker
// out_ch    out  valid/ready   packed_byte[7:0], final_byte
// cfg       in   cfg_we_i      cfg_idx_i[1:0], cfg_wdata_i[6:0]
//
// one character per cycle sustained while the queue has room; a request waits in the
// input register, its bytes are packed there and land in a two-entry result queue
// an end marker yields one or two bytes; two need both queue slots free
// (empty queue, or one entry leaving in the same cycle)
// reset clears pending bits, queue and registers to their defaults
// a stalled output holds the input register once the queue lacks room for its bytes

module packed_text_encoder_unit import pte_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  pte_in_if.sink              in_ch,
  pte_out_if.source           out_ch
);

  cfg_t       cfg_q;
  logic       in_vld_q;
  logic [7:0] char_q;
  logic       end_q;
  logic       adv;
  logic [1:0] space;
  code_t      code;
  pack_res_t  res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= MODE_NUMERIC;
      cfg_q.digit_stop <= DigitStopRst;
      cfg_q.alnum_stop <= AlnumStopRst;
      cfg_q.ascii_stop <= AsciiStopRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CODE_MODE:  cfg_q.mode       <= code_mode_e'(cfg_wdata_i[1:0]);
        REG_DIGIT_STOP: cfg_q.digit_stop <= cfg_wdata_i[3:0];
        REG_ALNUM_STOP: cfg_q.alnum_stop <= cfg_wdata_i[5:0];
        REG_ASCII_STOP: cfg_q.ascii_stop <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // input register advances when the queue has room for all results
  assign adv         = in_vld_q && (res.count <= space);
  assign in_ch.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      char_q <= in_ch.text_char;
      end_q  <= in_ch.end_marker;
    end
  end

  pte_coder u_coder (
    .cfg_i        (cfg_q),
    .text_char_i  (char_q),
    .end_marker_i (end_q),
    .code_o       (code)
  );

  pte_packer u_packer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .code_i       (code),
    .end_marker_i (end_q),
    .adv_i        (adv),
    .res_o        (res)
  );

  pte_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (adv),
    .res_i   (res),
    .space_o (space),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

/* design/pte_coder.sv */
`timescale 1ns / 1ps
`default_nettype none

module pte_coder import pte_pkg::*; (
  input  cfg_t       cfg_i,
  input  logic [7:0] text_char_i,
  input  logic       end_marker_i,
  output code_t      code_o
);

  logic [7:0] char_code;
  logic [7:0] stop_code;
  logic [7:0] digit_off;
  logic [7:0] alpha_off;
  logic [7:0] other_off;

  assign digit_off = text_char_i - CharZero;
  assign alpha_off = text_char_i - AlphaBias;
  assign other_off = text_char_i - OtherBias;

  // character code and stop code for the current mode
  always_comb begin
    char_code = 8'd0;
    stop_code = 8'd0;
    code_o.width = WidthAscii;
    unique case (cfg_i.mode)
      MODE_NUMERIC: begin
        code_o.width = WidthNumeric;
        char_code = {4'd0, digit_off[3:0]};
        stop_code = {4'd0, cfg_i.digit_stop};
      end
      MODE_ALNUM: begin
        code_o.width = WidthAlnum;
        stop_code = {2'd0, cfg_i.alnum_stop};
        if (text_char_i >= CharZero && text_char_i <= CharNine) begin
          char_code = digit_off;
        end else if (text_char_i >= CharUpperA && text_char_i <= CharUpperZ) begin
          char_code = alpha_off;
        end else begin
          char_code = {2'd0, other_off[5:0]};
        end
      end
      MODE_ASCII, MODE_SPARE: begin
        code_o.width = WidthAscii;
        char_code = {1'b0, text_char_i[6:0]};
        stop_code = {1'b0, cfg_i.ascii_stop};
      end
      default: begin
        code_o.width = WidthAscii;
      end
    endcase
    // end marker takes the stop code instead of the character
    code_o.code = end_marker_i ? stop_code[6:0] : char_code[6:0];
  end

endmodule

`default_nettype wire

/* design/pte_packer.sv */
`timescale 1ns / 1ps
`default_nettype none

module pte_packer import pte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  code_t     code_i,
  input  logic      end_marker_i,
  input  logic      adv_i,
  output pack_res_t res_o
);

  logic [6:0]  pend_q, pend_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [13:0] acc;
  logic [3:0]  total;
  logic        emit;
  logic [2:0]  rem;
  logic [7:0]  head;
  logic [6:0]  keep;
  logic        flush;
  logic [7:0]  tail;
  logic [13:0] head_wide;
  logic [7:0]  tail_wide;

  // append the code to the pending bits
  assign acc   = ({7'd0, pend_q} << code_i.width) | {7'd0, code_i.code};
  assign total = {1'b0, cnt_q} + {1'b0, code_i.width};
  assign emit  = total[3];
  assign rem   = total[2:0];

  // completed byte and bits left over
  assign head_wide = acc >> rem;
  assign head      = head_wide[7:0];
  assign keep      = acc[6:0] & ~(7'h7F << rem);

  // zero-padded flush of the leftover bits
  assign flush     = end_marker_i && (rem != 3'd0);
  assign tail_wide = {1'b0, keep} << (4'd8 - {1'b0, rem});
  assign tail      = tail_wide;

  // result assembly
  always_comb begin
    res_o.count       = 2'd0;
    res_o.first.data  = head;
    res_o.first.fin   = 1'b0;
    res_o.second.data = tail;
    res_o.second.fin  = 1'b1;
    if (emit && flush) begin
      res_o.count = 2'd2;
    end else if (emit) begin
      res_o.count     = 2'd1;
      res_o.first.fin = end_marker_i;
    end else if (flush) begin
      res_o.count      = 2'd1;
      res_o.first.data = tail;
      res_o.first.fin  = 1'b1;
    end
  end

  // pending state update
  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (adv_i) begin
      if (end_marker_i) begin
        pend_d = 7'd0;
        cnt_d  = 3'd0;
      end else begin
        pend_d = keep;
        cnt_d  = rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 7'd0;
      cnt_q  <= 3'd0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* design/pte_out_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module pte_out_queue import pte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  pack_res_t   res_i,
  output logic [1:0]  space_o,
  pte_out_if.source   out_ch
);

  res_item_t  ent_q [2];
  res_item_t  ent_d [2];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] cnt_left;
  logic [1:0] n_push;
  logic       pop;

  assign out_ch.valid       = (cnt_q != 2'd0);
  assign out_ch.packed_byte = ent_q[0].data;
  assign out_ch.final_byte  = ent_q[0].fin;

  assign pop      = out_ch.valid && out_ch.ready;
  assign space_o  = 2'd2 - cnt_q + {1'b0, pop};
  assign cnt_left = cnt_q - {1'b0, pop};
  assign n_push   = push_i ? res_i.count : 2'd0;
  assign cnt_d    = cnt_left + n_push;

  // shift out the head, then append new results
  always_comb begin
    ent_d[0] = pop ? ent_q[1] : ent_q[0];
    ent_d[1] = ent_q[1];
    if (n_push != 2'd0) begin
      if (cnt_left == 2'd0) begin
        ent_d[0] = res_i.first;
        ent_d[1] = res_i.second;
      end else begin
        ent_d[1] = res_i.first;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire
